>>> rtl/trdec_pkg.sv
// Package for the token run-length record decoder.
// Holds item and result types, parser phase and token enums and token byte codes.
// No dependencies.
package trdec_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TOKEN = 3'd1,
    PH_ARGS  = 3'd2,
    PH_RUN   = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    TT_ZERO = 2'd0,
    TT_LIT  = 2'd1,
    TT_REP  = 2'd2
  } token_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_BAD_COUNT = 3'd2,
    ST_NO_LIT    = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_RUN_BYTE  = 3'd5
  } status_e;

  localparam logic [7:0] TOK_ZERO = 8'h00;
  localparam logic [7:0] TOK_LIT  = 8'hFF;
  localparam logic [7:0] TOK_REP  = 8'hAA;

  localparam logic [3:0] COUNT_BYTES = 4'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] record_total;
    logic [7:0]  data_byte;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic        has_record;
    logic [63:0] record_low;
    logic [31:0] record_high;
    logic [31:0] record_index;
    logic        frame_done;
    status_e     status;
  } result_t;

endpackage

>>> rtl/trdec_inbuf.sv
// Input register of the decoder: holds one accepted word until the core takes it.
// Depends on trdec_pkg.
module trdec_inbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  trdec_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            take_i,
  output trdec_pkg::item_t item_o
);
  import trdec_pkg::*;

  logic  vld_q;
  item_t item_q;

  assign ready_o = !vld_q || take_i;
  assign valid_o = vld_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

>>> rtl/trdec_core.sv
// Parser core: frame, token and run state, updated once per word.
// Depends on trdec_pkg.
module trdec_core #(
  parameter int RECORD_BYTES = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  trdec_pkg::item_t  item_i,
  output logic              emit_o,
  output trdec_pkg::result_t res_o
);
  import trdec_pkg::*;

  localparam logic [3:0] NeedLit = 4'(RECORD_BYTES);

  phase_e      phase_q, phase_d;
  token_e      tt_q, tt_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] glo_q, glo_d;
  logic [31:0] ghi_q, ghi_d;
  logic [63:0] slo_q, slo_d;
  logic [31:0] shi_q, shi_d;
  logic        sv_q, sv_d;
  logic [31:0] filled_q, filled_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] run_q, run_d;
  logic        bend_q, bend_d;

  logic [63:0] nlo;
  logic [31:0] nhi;
  logic [3:0]  npos;
  logic [3:0]  need;
  logic [31:0] cnt;
  logic        tok_ok;
  logic [63:0] rlo;
  logic [31:0] rhi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tt_q     <= TT_ZERO;
      pos_q    <= '0;
      glo_q    <= '0;
      ghi_q    <= '0;
      sv_q     <= 1'b0;
      filled_q <= '0;
      remain_q <= '0;
      run_q    <= '0;
      bend_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tt_q     <= tt_d;
      pos_q    <= pos_d;
      glo_q    <= glo_d;
      ghi_q    <= ghi_d;
      sv_q     <= sv_d;
      filled_q <= filled_d;
      remain_q <= remain_d;
      run_q    <= run_d;
      bend_q   <= bend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      slo_q <= slo_d;
      shi_q <= shi_d;
    end
  end

  // byte lane insert into the gather word
  always_comb begin
    nlo = glo_q;
    nhi = ghi_q;
    for (int i = 0; i < 8; i++) begin
      if (pos_q == 4'(i)) nlo[8*i +: 8] = item_i.data_byte;
    end
    for (int i = 0; i < 4; i++) begin
      if (pos_q == 4'(i + 8)) nhi[8*i +: 8] = item_i.data_byte;
    end
    npos = pos_q + 4'd1;
    need = (tt_q == TT_LIT) ? NeedLit : COUNT_BYTES;
    cnt  = nlo[31:0];
    rlo  = (tt_q == TT_REP && sv_q) ? slo_q : '0;
    rhi  = (tt_q == TT_REP && sv_q) ? shi_q : '0;
  end

  always_comb begin
    phase_d  = phase_q;
    tt_d     = tt_q;
    pos_d    = pos_q;
    glo_d    = glo_q;
    ghi_d    = ghi_q;
    slo_d    = slo_q;
    shi_d    = shi_q;
    sv_d     = sv_q;
    filled_d = filled_q;
    remain_d = remain_q;
    run_d    = run_q;
    bend_d   = bend_q;
    emit_o   = 1'b0;
    res_o    = '0;
    tok_ok   = 1'b0;

    case (item_i.kind)
      KIND_START: begin
        tt_d     = TT_ZERO;
        pos_d    = '0;
        glo_d    = '0;
        ghi_d    = '0;
        sv_d     = 1'b0;
        filled_d = '0;
        remain_d = item_i.record_total;
        run_d    = '0;
        bend_d   = 1'b0;
        if (item_i.record_total == '0) begin
          emit_o           = 1'b1;
          res_o.frame_done = 1'b1;
          phase_d          = PH_DONE;
        end else begin
          phase_d = PH_TOKEN;
        end
      end

      KIND_BYTE: begin
        case (phase_q)
          PH_RUN: begin
            emit_o           = 1'b1;
            res_o.frame_done = 1'b1;
            res_o.status     = ST_RUN_BYTE;
            phase_d          = PH_DONE;
          end
          PH_TOKEN: begin
            glo_d = '0;
            ghi_d = '0;
            pos_d = '0;
            if (item_i.data_byte == TOK_ZERO) begin
              tt_d   = TT_ZERO;
              tok_ok = 1'b1;
            end else if (item_i.data_byte == TOK_LIT) begin
              tt_d   = TT_LIT;
              tok_ok = 1'b1;
            end else if (item_i.data_byte == TOK_REP) begin
              if (sv_q) begin
                tt_d   = TT_REP;
                tok_ok = 1'b1;
              end else begin
                emit_o           = 1'b1;
                res_o.frame_done = 1'b1;
                res_o.status     = ST_NO_LIT;
                phase_d          = PH_DONE;
              end
            end else begin
              emit_o           = 1'b1;
              res_o.frame_done = 1'b1;
              res_o.status     = ST_UNKNOWN;
              phase_d          = PH_DONE;
            end
            if (tok_ok) begin
              if (item_i.last_byte) begin
                emit_o           = 1'b1;
                res_o.frame_done = 1'b1;
                res_o.status     = ST_TRUNC;
                phase_d          = PH_DONE;
              end else begin
                phase_d = PH_ARGS;
              end
            end
          end
          PH_ARGS: begin
            glo_d = nlo;
            ghi_d = nhi;
            pos_d = npos;
            if (npos < need) begin
              if (item_i.last_byte) begin
                emit_o           = 1'b1;
                res_o.frame_done = 1'b1;
                res_o.status     = ST_TRUNC;
                phase_d          = PH_DONE;
              end
            end else if (tt_q == TT_LIT) begin
              slo_d              = nlo;
              shi_d              = nhi;
              sv_d               = 1'b1;
              filled_d           = filled_q + 32'd1;
              remain_d           = remain_q - 32'd1;
              emit_o             = 1'b1;
              res_o.has_record   = 1'b1;
              res_o.record_low   = nlo;
              res_o.record_high  = nhi;
              res_o.record_index = filled_q;
              if (remain_q == 32'd1) begin
                res_o.frame_done = 1'b1;
                phase_d          = PH_DONE;
              end else if (item_i.last_byte) begin
                res_o.frame_done = 1'b1;
                res_o.status     = ST_TRUNC;
                phase_d          = PH_DONE;
              end else begin
                phase_d = PH_TOKEN;
              end
            end else if (cnt == '0 || cnt > remain_q) begin
              emit_o           = 1'b1;
              res_o.frame_done = 1'b1;
              res_o.status     = ST_BAD_COUNT;
              phase_d          = PH_DONE;
            end else begin
              run_d   = cnt;
              bend_d  = item_i.last_byte;
              phase_d = PH_RUN;
            end
          end
          default: begin
          end
        endcase
      end

      KIND_TICK: begin
        if (phase_q == PH_RUN) begin
          filled_d           = filled_q + 32'd1;
          remain_d           = remain_q - 32'd1;
          run_d              = run_q - 32'd1;
          emit_o             = 1'b1;
          res_o.has_record   = 1'b1;
          res_o.record_low   = rlo;
          res_o.record_high  = rhi;
          res_o.record_index = filled_q;
          if (run_q != 32'd1) begin
            phase_d = PH_RUN;
          end else if (remain_q == 32'd1) begin
            res_o.frame_done = 1'b1;
            phase_d          = PH_DONE;
          end else if (bend_q) begin
            res_o.frame_done = 1'b1;
            res_o.status     = ST_TRUNC;
            phase_d          = PH_DONE;
          end else begin
            phase_d = PH_TOKEN;
          end
        end
      end

      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_done_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o && res_o.frame_done |=> phase_q == PH_DONE)
    else $error("frame end did not move parser to done");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RUN |-> run_q != '0 && run_q <= remain_q)
    else $error("run length exceeds records still missing");

  a_repeat_has_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ARGS || phase_q == PH_RUN) && tt_q == TT_REP |-> sv_q)
    else $error("repeat token active without remembered record");

  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.status != ST_OK |-> res_o.frame_done && !res_o.has_record
      || res_o.status == ST_TRUNC)
    else $error("error status without frame end");
`endif

endmodule

>>> rtl/trdec_outbuf.sv
// Result register of the decoder: holds one result word until the sink takes it.
// Depends on trdec_pkg.
module trdec_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  trdec_pkg::result_t res_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output trdec_pkg::result_t res_o
);
  import trdec_pkg::*;

  logic    vld_q;
  result_t res_q;

  assign free_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/token_run_length_record_decoder.sv
// Token run-length record decoder, top level.
// Depends on trdec_pkg, trdec_inbuf, trdec_core and trdec_outbuf.
//
// Takes one word per cycle: start, stream byte or tick. Each word is held in an
// input register, then the parser core updates its frame, token and run state
// and, when the word produces a result, loads it into the result register. A
// result passes through the input register and the result register before it is
// presented, and one word per cycle is sustained as long as the result side keeps
// taking words; a stalled result register holds the next word in the input register.
module token_run_length_record_decoder #(
  parameter int RECORD_BYTES = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] record_total_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_record_o,
  output logic [63:0] record_low_o,
  output logic [31:0] record_high_o,
  output logic [31:0] record_index_o,
  output logic        frame_done_o,
  output logic [2:0]  status_o
);
  import trdec_pkg::*;

  item_t   item_in;
  item_t   item_q;
  logic    item_vld;
  logic    step;
  logic    emit;
  logic    out_free;
  result_t res_d;
  result_t res_q;

  assign item_in.kind         = kind_i;
  assign item_in.record_total = record_total_i;
  assign item_in.data_byte    = data_byte_i;
  assign item_in.last_byte    = last_byte_i;

  assign step = item_vld && out_free;

  trdec_inbuf u_inbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (item_in),
    .valid_o (item_vld),
    .take_i  (step),
    .item_o  (item_q)
  );

  trdec_core #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .emit_o (emit),
    .res_o  (res_d)
  );

  trdec_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && emit),
    .res_i   (res_d),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_q)
  );

  assign has_record_o   = res_q.has_record;
  assign record_low_o   = res_q.record_low;
  assign record_high_o  = res_q.record_high;
  assign record_index_o = res_q.record_index;
  assign frame_done_o   = res_q.frame_done;
  assign status_o       = res_q.status;

endmodule

>>> sim/tb_token_run_length_record_decoder.sv
// Self-checking testbench for token_run_length_record_decoder.
// Random frames of tokens, ticks and errors are checked against an in-bench parser
// model. Depends on trdec_pkg and the decoder RTL.
module tb_token_run_length_record_decoder;
  import trdec_pkg::*;

  localparam int RECORD_BYTES = 12;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  // Parser model plus the queue of records still owed by the decoder.
  class record_scoreboard;
    phase_e      ph = PH_IDLE;
    token_e      tok = TT_ZERO;
    bit [3:0]    pos;
    bit [63:0]   acc_lo, lit_lo;
    bit [31:0]   acc_hi, lit_hi;
    bit          lit_ok, buf_end;
    bit [31:0]   filled, target, run_left;
    result_t     pending[$];
    int          errors;
    int          active_words;

    function void post(bit has, bit [63:0] lo, bit [31:0] hi, bit [31:0] idx, bit done,
                       status_e st);
      result_t r;
      r.has_record   = has;
      r.record_low   = lo;
      r.record_high  = hi;
      r.record_index = idx;
      r.frame_done   = done;
      r.status       = st;
      pending.push_back(r);
      if (done) ph = PH_DONE;
    endfunction

    function void post_error(status_e st);
      post(1'b0, '0, '0, '0, 1'b1, st);
    endfunction

    function void byte_word(bit [7:0] b, bit last);
      bit [31:0] n, idx;
      int need;
      if (ph == PH_RUN) begin
        post_error(ST_RUN_BYTE);
        return;
      end
      if (ph == PH_TOKEN) begin
        acc_lo = '0;
        acc_hi = '0;
        pos = '0;
        if (b == TOK_ZERO) tok = TT_ZERO;
        else if (b == TOK_LIT) tok = TT_LIT;
        else if (b == TOK_REP) begin
          if (!lit_ok) begin
            post_error(ST_NO_LIT);
            return;
          end
          tok = TT_REP;
        end else begin
          post_error(ST_UNKNOWN);
          return;
        end
        if (last) post_error(ST_TRUNC);
        else ph = PH_ARGS;
        return;
      end
      if (ph != PH_ARGS) return;
      need = (tok == TT_LIT) ? RECORD_BYTES : int'(COUNT_BYTES);
      if (pos < 8) acc_lo |= 64'(b) << (8 * pos);
      else if (pos < 12) acc_hi |= 32'(b) << (8 * (pos - 8));
      pos++;
      if (pos < need) begin
        if (last) post_error(ST_TRUNC);
        return;
      end
      if (tok == TT_LIT) begin
        idx = filled;
        lit_lo = acc_lo;
        lit_hi = acc_hi;
        lit_ok = 1'b1;
        filled++;
        if (filled == target) post(1'b1, acc_lo, acc_hi, idx, 1'b1, ST_OK);
        else if (last) post(1'b1, acc_lo, acc_hi, idx, 1'b1, ST_TRUNC);
        else begin
          ph = PH_TOKEN;
          post(1'b1, acc_lo, acc_hi, idx, 1'b0, ST_OK);
        end
        return;
      end
      n = acc_lo[31:0];
      if (n == 0 || n > target - filled) post_error(ST_BAD_COUNT);
      else begin
        run_left = n;
        buf_end = last;
        ph = PH_RUN;
      end
    endfunction

    function void tick_word();
      bit [63:0] lo;
      bit [31:0] hi, idx;
      if (ph != PH_RUN) return;
      lo = '0;
      hi = '0;
      if (tok == TT_REP && lit_ok) begin
        lo = lit_lo;
        hi = lit_hi;
      end
      idx = filled;
      filled++;
      run_left--;
      if (run_left != 0) post(1'b1, lo, hi, idx, 1'b0, ST_OK);
      else if (filled == target) post(1'b1, lo, hi, idx, 1'b1, ST_OK);
      else if (buf_end) post(1'b1, lo, hi, idx, 1'b1, ST_TRUNC);
      else begin
        ph = PH_TOKEN;
        post(1'b1, lo, hi, idx, 1'b0, ST_OK);
      end
    endfunction

    function void note_word(logic [1:0] kind, logic [31:0] total, logic [7:0] b, logic last);
      case (kind)
        KIND_START: begin
          active_words++;
          tok = TT_ZERO;
          pos = '0;
          acc_lo = '0;
          acc_hi = '0;
          lit_ok = 1'b0;
          filled = '0;
          target = total;
          run_left = '0;
          buf_end = 1'b0;
          if (total == 0) post(1'b0, '0, '0, '0, 1'b1, ST_OK);
          else ph = PH_TOKEN;
        end
        KIND_BYTE: begin
          if (ph != PH_IDLE && ph != PH_DONE) active_words++;
          byte_word(b, last);
        end
        KIND_TICK: begin
          if (ph == PH_RUN) active_words++;
          tick_word();
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected record: has=%0d low=%h high=%h index=%0d done=%0d status=%0d",
                   got.has_record, got.record_low, got.record_high, got.record_index,
                   got.frame_done, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.has_record !== want.has_record || got.record_low !== want.record_low ||
          got.record_high !== want.record_high || got.record_index !== want.record_index ||
          got.frame_done !== want.frame_done || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("record mismatch: expected has=%0d low=%h high=%h index=%0d done=%0d st=%0d",
                   want.has_record, want.record_low, want.record_high, want.record_index,
                   want.frame_done, want.status);
          $display("                 actual   has=%0d low=%h high=%h index=%0d done=%0d st=%0d",
                   got.has_record, got.record_low, got.record_high, got.record_index,
                   got.frame_done, got.status);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_START;
  logic [31:0] record_total_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        has_record_o;
  logic [63:0] record_low_o;
  logic [31:0] record_high_o;
  logic [31:0] record_index_o;
  logic        frame_done_o;
  logic [2:0]  status_o;

  record_scoreboard model = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;

  token_run_length_record_decoder #(.RECORD_BYTES(RECORD_BYTES)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .record_total_i (record_total_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .has_record_o   (has_record_o),
    .record_low_o   (record_low_o),
    .record_high_o  (record_high_o),
    .record_index_o (record_index_o),
    .frame_done_o   (frame_done_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_token_run_length_record_decoder: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_count(logic [31:0] missing);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, (missing > 6) ? 6 : missing);
    if (r < 86) return '0;
    if (r < 93) return missing + 1;
    return $urandom();
  endfunction

  task automatic send_word(logic [1:0] kind, logic [31:0] total, logic [7:0] b, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    record_total_i <= total;
    data_byte_i    <= b;
    last_byte_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model.note_word(kind, total, b, last);
  endtask

  task automatic put_byte(logic [7:0] b, logic last);
    send_word(KIND_BYTE, $urandom(), b, last);
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, $urandom(), 8'($urandom()), 1'($urandom()));
  endtask

  task automatic open_frame(logic [31:0] total);
    send_word(KIND_START, total, 8'($urandom()), 1'($urandom()));
  endtask

  task automatic send_count(logic [7:0] token, logic [31:0] n, bit last);
    put_byte(token, 1'b0);
    for (int i = 0; i < 4; i++) put_byte(n[8*i +: 8], last && i == 3);
  endtask

  task automatic send_literal(bit last, bit ones);
    put_byte(TOK_LIT, 1'b0);
    for (int i = 0; i < RECORD_BYTES; i++)
      put_byte(ones ? 8'hFF : 8'($urandom()), last && i == RECORD_BYTES - 1);
  endtask

  task automatic random_frame();
    logic [31:0] total, missing, n;
    logic [7:0]  tb;
    bit          lit_seen, closed, fin;
    int          r, k, span, need;
    r = $urandom_range(0, 99);
    if (r < 5) total = '0;
    else if (r < 15) total = $urandom();
    else total = $urandom_range(1, 10);
    open_frame(total);
    missing = total;
    lit_seen = 1'b0;
    closed = (total == 0);
    while (!closed) begin
      r = $urandom_range(0, 99);
      fin = ($urandom_range(0, 15) == 0);
      if (r < 12) begin
        case ($urandom_range(0, 5))
          0: begin
            tb = 8'($urandom());
            if (tb == TOK_ZERO || tb == TOK_LIT || tb == TOK_REP) tb = 8'h5A;
            put_byte(tb, fin);
            closed = 1'b1;
          end
          1: begin
            tb = ($urandom_range(0, 1) != 0) ? TOK_LIT : TOK_ZERO;
            need = (tb == TOK_LIT) ? RECORD_BYTES : int'(COUNT_BYTES);
            k = $urandom_range(0, need - 1);
            put_byte(tb, k == 0);
            for (int i = 1; i <= k; i++) put_byte(8'($urandom()), i == k);
            closed = 1'b1;
          end
          2: begin
            if (!lit_seen) put_byte(TOK_REP, fin);
            closed = 1'b1;
          end
          3: begin
            send_tick();
            send_word(KIND_SPARE, $urandom(), 8'($urandom()), 1'($urandom()));
          end
          4: closed = 1'b1;
          default: begin
            send_count(TOK_ZERO, $urandom_range(1, (missing > 6) ? 6 : missing), 1'b0);
            put_byte(8'($urandom()), fin);
            closed = 1'b1;
          end
        endcase
      end else if (r < 55) begin
        tb = (lit_seen && r >= 35) ? TOK_REP : TOK_ZERO;
        n = pick_count(missing);
        send_count(tb, n, fin);
        if (n == 0 || n > missing) closed = 1'b1;
        else begin
          span = (n > 16) ? $urandom_range(0, 4) : int'(n);
          for (k = 0; k < span && !closed; k++) begin
            if ($urandom_range(0, 49) == 0) begin
              put_byte(8'($urandom()), 1'($urandom()));
              closed = 1'b1;
            end else send_tick();
          end
          if (!closed && span < n) begin
            put_byte(8'($urandom()), 1'($urandom()));
            closed = 1'b1;
          end
          missing = missing - n;
          closed = closed || missing == 0 || fin;
        end
      end else begin
        send_literal(fin, 1'b0);
        lit_seen = 1'b1;
        missing--;
        closed = missing == 0 || fin;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      send_tick();
      put_byte(8'($urandom()), 1'($urandom()));
    end
  endtask

  initial begin
    int stall;
    result_t got;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.has_record   = has_record_o;
        got.record_low   = record_low_o;
        got.record_high  = record_high_o;
        got.record_index = record_index_o;
        got.frame_done   = frame_done_o;
        got.status       = status_e'(status_o);
        model.check_result(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else out_ready_i <= 1'b1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no frame open yet: all ignored, then an empty frame ends at once
    send_tick();
    put_byte(TOK_LIT, 1'b0);
    send_word(KIND_SPARE, '1, 8'hFF, 1'b1);
    open_frame('0);
    // repeat with nothing remembered, on the final byte
    open_frame('1);
    put_byte(TOK_REP, 1'b1);
    open_frame(32'd2);
    put_byte(8'h5A, 1'b0);
    // one all-ones literal completes the frame on the final byte
    open_frame(32'd1);
    send_literal(1'b1, 1'b1);
    send_tick();

    quiet = 1'b1;
    repeat (3) random_frame();
    quiet = 1'b0;

    // long receiver hold-off while a run keeps producing records
    open_frame(32'd40);
    send_count(TOK_ZERO, 32'd40, 1'b0);
    hold_req = 1'b1;
    repeat (40) send_tick();

    while (model.active_words < 450) random_frame();
    in_valid_i <= 1'b0;
    quiet = 1'b1;
    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (model.errors == 0) $display("tb_token_run_length_record_decoder: PASS");
    else $display("tb_token_run_length_record_decoder: FAIL");
    $finish;
  end

endmodule
